// ===== src/cgtr_pkg.sv =====
package cgtr_pkg;

  localparam int GLYPH_ROWS_DEFAULT = 16;
  localparam int CHAR_COUNT_DEFAULT = 256;
  localparam int COORD_BITS_DEFAULT = 16;

  localparam int GLYPH_WIDTH     = 8;
  localparam int FONT_INDEX_BITS = 12;
  localparam int FONT_BYTE_BITS  = 8;
  localparam int CHAR_BITS       = 8;
  localparam int COLOR_BITS      = 32;
  localparam int CFG_COORD_BITS  = 16;
  localparam int CLIP_SIZE_BITS  = 15;
  localparam int APB_DATA_BITS   = 32;
  localparam int APB_ADDR_BITS   = 5;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [CHAR_BITS-1:0] NEWLINE_CODE = 8'd10;

  localparam logic REQ_FONT = 1'b0;
  localparam logic REQ_CHAR = 1'b1;

  localparam int JOB_FIXED_BITS = 1 + FONT_INDEX_BITS + FONT_BYTE_BITS + COLOR_BITS;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_CLIP_X      = 3'd2,
    REG_CLIP_Y      = 3'd3,
    REG_CLIP_W      = 3'd4,
    REG_CLIP_H      = 3'd5,
    REG_WRAP_ENABLE = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [CFG_COORD_BITS-1:0] origin_x;
    logic signed [CFG_COORD_BITS-1:0] origin_y;
    logic signed [CFG_COORD_BITS-1:0] clip_x;
    logic signed [CFG_COORD_BITS-1:0] clip_y;
    logic [CLIP_SIZE_BITS-1:0]        clip_w;
    logic [CLIP_SIZE_BITS-1:0]        clip_h;
    logic                             wrap_enable;
  } cfg_t;

endpackage

// ===== src/cgtr_regs.sv =====
module cgtr_regs
  import cgtr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ORIGIN_X:    cfg.origin_x    <= pwdata[CFG_COORD_BITS-1:0];
        REG_ORIGIN_Y:    cfg.origin_y    <= pwdata[CFG_COORD_BITS-1:0];
        REG_CLIP_X:      cfg.clip_x      <= pwdata[CFG_COORD_BITS-1:0];
        REG_CLIP_Y:      cfg.clip_y      <= pwdata[CFG_COORD_BITS-1:0];
        REG_CLIP_W:      cfg.clip_w      <= pwdata[CLIP_SIZE_BITS-1:0];
        REG_CLIP_H:      cfg.clip_h      <= pwdata[CLIP_SIZE_BITS-1:0];
        REG_WRAP_ENABLE: cfg.wrap_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ORIGIN_X:    prdata[CFG_COORD_BITS-1:0] = cfg.origin_x;
      REG_ORIGIN_Y:    prdata[CFG_COORD_BITS-1:0] = cfg.origin_y;
      REG_CLIP_X:      prdata[CFG_COORD_BITS-1:0] = cfg.clip_x;
      REG_CLIP_Y:      prdata[CFG_COORD_BITS-1:0] = cfg.clip_y;
      REG_CLIP_W:      prdata[CLIP_SIZE_BITS-1:0] = cfg.clip_w;
      REG_CLIP_H:      prdata[CLIP_SIZE_BITS-1:0] = cfg.clip_h;
      REG_WRAP_ENABLE: prdata[0]                  = cfg.wrap_enable;
      default:         prdata                     = '0;
    endcase
  end

endmodule

// ===== src/cgtr_front.sv =====
module cgtr_front
  import cgtr_pkg::*;
#(
  parameter int GLYPH_ROWS = GLYPH_ROWS_DEFAULT,
  parameter int CHAR_COUNT = CHAR_COUNT_DEFAULT,
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cfg_t                                  cfg,
  input  logic                                  accept,
  input  logic                                  req_type,
  input  logic [FONT_INDEX_BITS-1:0]            font_index,
  input  logic [FONT_BYTE_BITS-1:0]             font_byte,
  input  logic [CHAR_BITS-1:0]                  char_code,
  input  logic                                  first_of_string,
  input  logic [COLOR_BITS-1:0]                 color,
  output logic                                  push_valid,
  output logic [JOB_FIXED_BITS+2*COORD_BITS-1:0] push_data
);

  localparam int C     = COORD_BITS;
  localparam int WB    = ((C > 18) ? C : 18) + 2;
  localparam int DEPTH = CHAR_COUNT * GLYPH_ROWS;

  localparam logic signed [WB-1:0] COORD_MAX = {{(WB-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [WB-1:0] COORD_MIN = {{(WB-C+1){1'b1}}, {(C-1){1'b0}}};
  localparam logic signed [WB-1:0] STEP_X    = WB'(GLYPH_WIDTH);
  localparam logic signed [WB-1:0] STEP_Y    = WB'(GLYPH_ROWS);

  typedef struct packed {
    logic                       draw;
    logic [FONT_INDEX_BITS-1:0] index;
    logic [FONT_BYTE_BITS-1:0]  data;
    logic signed [C-1:0]        x;
    logic signed [C-1:0]        y;
    logic [COLOR_BITS-1:0]      color;
  } job_t;

  function automatic logic signed [WB-1:0] wide(input logic signed [C-1:0] v);
    return {{(WB-C){v[C-1]}}, v};
  endfunction

  function automatic logic signed [WB-1:0] wide16(input logic signed [CFG_COORD_BITS-1:0] v);
    return {{(WB-CFG_COORD_BITS){v[CFG_COORD_BITS-1]}}, v};
  endfunction

  function automatic logic signed [C-1:0] sat(input logic signed [WB-1:0] v);
    logic signed [C-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[C-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[C-1:0];
    end else begin
      r = v[C-1:0];
    end
    return r;
  endfunction

  logic signed [C-1:0]  cursor_x, cursor_x_next;
  logic signed [C-1:0]  cursor_y, cursor_y_next;
  logic                 stopped, stopped_next;

  logic signed [C-1:0]  ox, oy, cur_x, cur_y, nl_y, draw_x, draw_y, adv_x;
  logic signed [WB-1:0] right, clip_w_w;
  logic                 stop_cur, newline, edge_stop, wrap_now, in_range;
  job_t                 job;

  assign ox       = sat(wide16(cfg.origin_x));
  assign oy       = sat(wide16(cfg.origin_y));
  assign clip_w_w = {{(WB-CLIP_SIZE_BITS){1'b0}}, cfg.clip_w};
  assign right    = wide16(cfg.clip_x) + clip_w_w;

  assign cur_x    = first_of_string ? ox : cursor_x;
  assign cur_y    = first_of_string ? oy : cursor_y;
  assign stop_cur = first_of_string ? 1'b0 : stopped;
  assign newline  = (char_code == NEWLINE_CODE);
  assign nl_y     = sat(wide(cur_y) + STEP_Y);

  assign edge_stop = !cfg.wrap_enable && (wide(cur_x) >= right);
  assign wrap_now  = cfg.wrap_enable && ((wide(cur_x) + STEP_X) > right);
  assign draw_x    = wrap_now ? ox : cur_x;
  assign draw_y    = wrap_now ? nl_y : cur_y;
  assign adv_x     = sat(wide(draw_x) + STEP_X);

  assign in_range  = 32'(font_index) < 32'(DEPTH);
  assign push_data = job;

  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    stopped_next  = stopped;
    push_valid    = 1'b0;
    job.draw      = 1'b0;
    job.index     = font_index;
    job.data      = font_byte;
    job.x         = draw_x;
    job.y         = draw_y;
    job.color     = color;
    if (accept) begin
      if (req_type == REQ_FONT) begin
        push_valid = in_range;
      end else begin
        cursor_x_next = cur_x;
        cursor_y_next = cur_y;
        stopped_next  = stop_cur;
        if (!stop_cur) begin
          if (newline) begin
            cursor_x_next = ox;
            cursor_y_next = nl_y;
          end else if (edge_stop) begin
            stopped_next = 1'b1;
          end else begin
            push_valid    = 1'b1;
            job.draw      = 1'b1;
            job.data      = char_code;
            cursor_x_next = adv_x;
            cursor_y_next = draw_y;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      stopped  <= 1'b0;
    end else begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      stopped  <= stopped_next;
    end
  end

endmodule

// ===== src/cgtr_queue.sv =====
module cgtr_queue
  import cgtr_pkg::*;
#(
  parameter int WIDTH = JOB_FIXED_BITS + 2 * COORD_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/cgtr_back.sv =====
module cgtr_back
  import cgtr_pkg::*;
#(
  parameter int GLYPH_ROWS = GLYPH_ROWS_DEFAULT,
  parameter int CHAR_COUNT = CHAR_COUNT_DEFAULT,
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cfg_t                                   cfg,
  input  logic                                   q_empty,
  input  logic [JOB_FIXED_BITS+2*COORD_BITS-1:0] pop_data,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [CFG_COORD_BITS-1:0]       pixel_x,
  output logic signed [CFG_COORD_BITS-1:0]       pixel_y,
  output logic [GLYPH_WIDTH-1:0]                 row_mask,
  output logic [COLOR_BITS-1:0]                  pixel_color,
  output logic                                   last_row
);

  localparam int C     = COORD_BITS;
  localparam int WB    = ((C > 18) ? C : 18) + 2;
  localparam int DEPTH = CHAR_COUNT * GLYPH_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(GLYPH_ROWS);

  localparam logic signed [WB-1:0] COORD_MAX = {{(WB-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [WB-1:0] COORD_MIN = {{(WB-C+1){1'b1}}, {(C-1){1'b0}}};

  typedef struct packed {
    logic                       draw;
    logic [FONT_INDEX_BITS-1:0] index;
    logic [FONT_BYTE_BITS-1:0]  data;
    logic signed [C-1:0]        x;
    logic signed [C-1:0]        y;
    logic [COLOR_BITS-1:0]      color;
  } job_t;

  function automatic logic signed [WB-1:0] wide(input logic signed [C-1:0] v);
    return {{(WB-C){v[C-1]}}, v};
  endfunction

  function automatic logic signed [WB-1:0] wide16(input logic signed [CFG_COORD_BITS-1:0] v);
    return {{(WB-CFG_COORD_BITS){v[CFG_COORD_BITS-1]}}, v};
  endfunction

  function automatic logic signed [C-1:0] sat(input logic signed [WB-1:0] v);
    logic signed [C-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[C-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[C-1:0];
    end else begin
      r = v[C-1:0];
    end
    return r;
  endfunction

  logic [FONT_BYTE_BITS-1:0] glyph_mem [DEPTH];

  job_t                      qjob;
  logic                      busy;
  logic [RW-1:0]             row;
  logic signed [C-1:0]       jx, jy;
  logic [COLOR_BITS-1:0]     jcolor;
  logic                      jblank;
  logic [AW-1:0]             jbase;
  logic [GLYPH_WIDTH-1:0]    jcols;

  logic                      s1_valid;
  logic signed [C-1:0]       s1_x, s1_y;
  logic [RW-1:0]             s1_row;
  logic [COLOR_BITS-1:0]     s1_color;
  logic                      s1_blank, s1_last;
  logic [GLYPH_WIDTH-1:0]    s1_cols;
  logic [FONT_BYTE_BITS-1:0] rd_data;

  logic                      issue, s1_ready, out_load, row_last;
  logic                      mem_we;
  logic [GLYPH_WIDTH-1:0]    col_mask;
  logic signed [WB-1:0]      right, bottom, py, s1_x_w, py_sat_w;
  logic                      row_ok;

  assign qjob     = job_t'(pop_data);
  assign right    = wide16(cfg.clip_x) + $signed({{(WB-CLIP_SIZE_BITS){1'b0}}, cfg.clip_w});
  assign bottom   = wide16(cfg.clip_y) + $signed({{(WB-CLIP_SIZE_BITS){1'b0}}, cfg.clip_h});

  assign pop      = !busy && !q_empty;
  assign mem_we   = pop && !qjob.draw;
  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign s1_ready = !s1_valid || out_load;
  assign issue    = busy && s1_ready;
  assign row_last = (row == RW'(GLYPH_ROWS - 1));

  always_comb begin
    logic signed [WB-1:0] px;
    col_mask = '0;
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      px = wide(qjob.x) + WB'(c);
      col_mask[GLYPH_WIDTH-1-c] = (px >= wide16(cfg.clip_x)) && (px < right);
    end
  end

  assign py       = wide(s1_y) + $signed({{(WB-RW){1'b0}}, s1_row});
  assign row_ok   = (py >= wide16(cfg.clip_y)) && (py < bottom);
  assign s1_x_w   = wide(s1_x);
  assign py_sat_w = wide(sat(py));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[AW'(qjob.index)] <= qjob.data;
    end
    if (issue) begin
      rd_data <= glyph_mem[jbase + AW'(row)];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && qjob.draw) begin
      jx     <= qjob.x;
      jy     <= qjob.y;
      jcolor <= qjob.color;
      jblank <= 32'(qjob.data) >= 32'(CHAR_COUNT);
      jbase  <= AW'(32'(qjob.data) * 32'(GLYPH_ROWS));
      jcols  <= col_mask;
    end
    if (issue) begin
      s1_x     <= jx;
      s1_y     <= jy;
      s1_row   <= row;
      s1_color <= jcolor;
      s1_blank <= jblank;
      s1_last  <= row_last;
      s1_cols  <= jcols;
    end
    if (out_load) begin
      pixel_x     <= s1_x_w[CFG_COORD_BITS-1:0];
      pixel_y     <= py_sat_w[CFG_COORD_BITS-1:0];
      row_mask    <= (s1_blank ? '0 : rd_data) & (row_ok ? s1_cols : '0);
      pixel_color <= s1_color;
      last_row    <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      row       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && qjob.draw) begin
        busy <= 1'b1;
        row  <= '0;
      end else if (issue) begin
        row <= row + 1'b1;
        if (row_last) begin
          busy <= 1'b0;
        end
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/clipped_glyph_text_renderer.sv =====
// A character job passes through the queue, job, glyph read and output registers.
// The back end reads one row per cycle while the output is not stalled, from the single read
// port of the glyph store, and pops no new job until a glyph's last row is issued.
// The front end takes one transaction per cycle while its 4-entry queue has room.
// Reset (rst, synchronous): clears registers, cursor, stop flag, queue and pipeline;
// the glyph store is not cleared and reads undefined until written.
module clipped_glyph_text_renderer
  import cgtr_pkg::*;
#(
  parameter int GLYPH_ROWS = GLYPH_ROWS_DEFAULT,
  parameter int CHAR_COUNT = CHAR_COUNT_DEFAULT,
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [APB_ADDR_BITS-1:0]         paddr,
  input  logic [APB_DATA_BITS-1:0]         pwdata,
  output logic [APB_DATA_BITS-1:0]         prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             req_type,
  input  logic [FONT_INDEX_BITS-1:0]       font_index,
  input  logic [FONT_BYTE_BITS-1:0]        font_byte,
  input  logic [CHAR_BITS-1:0]             char_code,
  input  logic                             first_of_string,
  input  logic [COLOR_BITS-1:0]            color,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [CFG_COORD_BITS-1:0] pixel_x,
  output logic signed [CFG_COORD_BITS-1:0] pixel_y,
  output logic [GLYPH_WIDTH-1:0]           row_mask,
  output logic [COLOR_BITS-1:0]            pixel_color,
  output logic                             last_row
);

  localparam int JOB_BITS = JOB_FIXED_BITS + 2 * COORD_BITS;

  cfg_t                cfg;
  logic                accept;
  logic                q_push, q_pop, q_full, q_empty;
  logic [JOB_BITS-1:0] q_push_data, q_pop_data;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  cgtr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cgtr_front #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .CHAR_COUNT (CHAR_COUNT),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .accept          (accept),
    .req_type        (req_type),
    .font_index      (font_index),
    .font_byte       (font_byte),
    .char_code       (char_code),
    .first_of_string (first_of_string),
    .color           (color),
    .push_valid      (q_push),
    .push_data       (q_push_data)
  );

  cgtr_queue #(
    .WIDTH (JOB_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  cgtr_back #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .CHAR_COUNT (CHAR_COUNT),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .pop_data    (q_pop_data),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .row_mask    (row_mask),
    .pixel_color (pixel_color),
    .last_row    (last_row)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_rows_back_to_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_row |=> out_valid)
    else $error("glyph rows interrupted");

endmodule
